// ----- rtl/bts_pkg.sv -----
package bts_pkg;

   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 512;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SIZE_W      = 10;
   localparam int POS_W       = 9;
   localparam int FRAC_W      = 16;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [31:0]       texel_type;
   typedef logic [FRAC_W-1:0] frac_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                  input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] s;
      s = r;
      if (r == '0) begin
         s = SIZE_W'(1);
      end else if (r > maxv) begin
         s = maxv;
      end
      return s;
   endfunction

endpackage

// ----- rtl/bts_req_if.sv -----
interface bts_req_if;
   import bts_pkg::*;
   logic      valid;
   logic      ready;
   logic      mode;
   addr_type  texel_index;
   texel_type texel_value;
   logic signed [31:0] coord_u;
   logic signed [31:0] coord_v;

   modport source (output valid, mode, texel_index, texel_value, coord_u, coord_v,
                   input ready);
   modport sink (input valid, mode, texel_index, texel_value, coord_u, coord_v,
                 output ready);
endinterface

interface bts_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] filtered_color;

   modport source (output valid, filtered_color, input ready);
   modport sink (input valid, filtered_color, output ready);
endinterface

// ----- rtl/bts_filter.sv -----
module bts_filter
   import bts_pkg::*;
(
   input  logic      clock,
   input  logic      adv,
   input  texel_type t00,
   input  texel_type t10,
   input  texel_type t01,
   input  texel_type t11,
   input  frac_type  fx,
   input  frac_type  fy,
   output texel_type color
);

   logic [23:0] top_ff [4];
   logic [23:0] bot_ff [4];
   logic [23:0] top_in [4];
   logic [23:0] bot_in [4];
   logic [39:0] acc_ff [4];
   logic [39:0] acc_in [4];
   frac_type    fy_ff;
   texel_type   color_ff;
   texel_type   color_in;
   logic [16:0] wx0;
   logic [16:0] wy0;
   logic [40:0] rnd;

   assign wx0 = 17'h10000 - {1'b0, fx};
   assign wy0 = 17'h10000 - {1'b0, fy_ff};

   always_comb begin
      color_in = '0;
      rnd      = '0;
      for (int k = 0; k < 4; k++) begin
         top_in[k] = 24'(t00[8*k +: 8]) * 24'(wx0) + 24'(t10[8*k +: 8]) * 24'(fx);
         bot_in[k] = 24'(t01[8*k +: 8]) * 24'(wx0) + 24'(t11[8*k +: 8]) * 24'(fx);
         acc_in[k] = 40'(top_ff[k]) * 40'(wy0) + 40'(bot_ff[k]) * 40'(fy_ff);
         rnd = {1'b0, acc_ff[k]} + 41'h0080000000;
         color_in[8*k +: 8] = (rnd[40:32] > 9'd255) ? 8'hff : rnd[39:32];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         top_ff   <= top_in;
         bot_ff   <= bot_in;
         fy_ff    <= fy;
         acc_ff   <= acc_in;
         color_ff <= color_in;
      end
   end

   assign color = color_ff;

endmodule

// ----- rtl/bilinear_rgba8_texel_sampler_unit.sv -----
// Bilinear RGBA8 sampler with a 512x512 texel store. Write words (mode 0) store a
// texel, sample words (mode 1) return one filtered color. One word is taken every
// cycle unless stalled; a sample result passes coordinate multiply, clamp, row
// offset, store read, two blend stages and rounding, each registered. The store
// is kept as two copies with two read ports each so all four neighbours are read
// in the same cycle. A stall on the result side halts the whole pipeline. The
// user must write image size registers only while the block is idle (unenforced).
module bilinear_rgba8_texel_sampler_unit
   import bts_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   bts_req_if.sink         req_bus,
   bts_rsp_if.source       rsp_bus,
   input  logic            csr_wr_en,
   input  logic            csr_index,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   logic [SIZE_W-1:0] width_ff, height_ff, w, h;
   logic adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(MAX_WIDTH);
         height_ff <= SIZE_W'(MAX_HEIGHT);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign w = eff_size(width_ff, SIZE_W'(MAX_WIDTH));
   assign h = eff_size(height_ff, SIZE_W'(MAX_HEIGHT));

   // valid bits per stage
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic wr1_ff, wr2_ff, wr3_ff;
   addr_type  idx1_ff, idx2_ff, idx3_ff;
   texel_type val1_ff, val2_ff, val3_ff;

   assign adv           = ~v7_ff | rsp_bus.ready;
   assign req_bus.ready = adv;

   // stage 1: coordinate times size
   logic signed [43:0] pu1_ff, pv1_ff, pu1_in, pv1_in;
   assign pu1_in = 44'(req_bus.coord_u) * 44'($signed({1'b0, w})) - 44'sd32768;
   assign pv1_in = 44'(req_bus.coord_v) * 44'($signed({1'b0, h})) - 44'sd32768;

   // stage 2: clamp and split
   logic [24:0] px, py, hix, hiy;
   logic [POS_W-1:0] x0_ff, x1_ff, y0_ff, y1_ff, x1_in, y1_in;
   frac_type fx2_ff, fy2_ff, fx3_ff, fy3_ff, fx4_ff, fy4_ff;

   assign hix = {w[POS_W-1:0] - POS_W'(1), 16'h0};
   assign hiy = {h[POS_W-1:0] - POS_W'(1), 16'h0};

   always_comb begin
      if (pu1_ff < 0) px = '0;
      else if (pu1_ff > $signed({19'b0, hix})) px = hix;
      else px = pu1_ff[24:0];
      if (pv1_ff < 0) py = '0;
      else if (pv1_ff > $signed({19'b0, hiy})) py = hiy;
      else py = pv1_ff[24:0];
      x1_in = (({1'b0, px[24:16]} + SIZE_W'(1)) < w) ? px[24:16] + POS_W'(1)
                                                     : w[POS_W-1:0] - POS_W'(1);
      y1_in = (({1'b0, py[24:16]} + SIZE_W'(1)) < h) ? py[24:16] + POS_W'(1)
                                                     : h[POS_W-1:0] - POS_W'(1);
   end

   // stage 3: linear addresses
   addr_type a00_ff, a10_ff, a01_ff, a11_ff;
   logic [18:0] r0, r1;
   assign r0 = y0_ff * w;
   assign r1 = y1_ff * w;

   // stage 4: store
   texel_type mem_a [STORE_DEPTH];
   texel_type mem_b [STORE_DEPTH];
   texel_type t00_ff, t10_ff, t01_ff, t11_ff;

   always_ff @(posedge clock) begin
      if (adv && v3_ff && wr3_ff) begin
         mem_a[idx3_ff] <= val3_ff;
         mem_b[idx3_ff] <= val3_ff;
      end
      if (adv) begin
         t00_ff <= mem_a[a00_ff];
         t10_ff <= mem_a[a10_ff];
         t01_ff <= mem_b[a01_ff];
         t11_ff <= mem_b[a11_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pu1_ff  <= pu1_in;
         pv1_ff  <= pv1_in;
         wr1_ff  <= (req_bus.mode == MODE_WRITE);
         idx1_ff <= req_bus.texel_index;
         val1_ff <= req_bus.texel_value;
         x0_ff   <= px[24:16];
         y0_ff   <= py[24:16];
         x1_ff   <= x1_in;
         y1_ff   <= y1_in;
         fx2_ff  <= px[15:0];
         fy2_ff  <= py[15:0];
         wr2_ff  <= wr1_ff;
         idx2_ff <= idx1_ff;
         val2_ff <= val1_ff;
         a00_ff  <= ADDR_W'(r0 + 19'(x0_ff));
         a10_ff  <= ADDR_W'(r0 + 19'(x1_ff));
         a01_ff  <= ADDR_W'(r1 + 19'(x0_ff));
         a11_ff  <= ADDR_W'(r1 + 19'(x1_ff));
         fx3_ff  <= fx2_ff;
         fy3_ff  <= fy2_ff;
         wr3_ff  <= wr2_ff;
         idx3_ff <= idx2_ff;
         val3_ff <= val2_ff;
         fx4_ff  <= fx3_ff;
         fy4_ff  <= fy3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_bus.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff & ~wr3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   bts_filter u_filter (
      .clock (clock),
      .adv   (adv),
      .t00   (t00_ff),
      .t10   (t10_ff),
      .t01   (t01_ff),
      .t11   (t11_ff),
      .fx    (fx4_ff),
      .fy    (fy4_ff),
      .color (rsp_bus.filtered_color)
   );

   assign rsp_bus.valid = v7_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input taken while result stalled");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (adv && v3_ff && wr3_ff) |=> !v4_ff)
      else $error("write word produced a result");

   a_sizes_in_range: assert property (@(posedge clock) disable iff (reset)
      w != '0 && h != '0 && w <= SIZE_W'(MAX_WIDTH) && h <= SIZE_W'(MAX_HEIGHT))
      else $error("effective size out of range");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> $stable(rsp_bus.filtered_color))
      else $error("result changed while stalled");

endmodule

// ----- tb/tb.sv -----
module tb;
   import bts_pkg::*;

   typedef struct packed {
      logic               mode;
      addr_type           texel_index;
      texel_type          texel_value;
      logic signed [31:0] coord_u;
      logic signed [31:0] coord_v;
   } sampler_word_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_index;
   logic [SIZE_W-1:0] csr_wr_data;

   bts_req_if req_bus();
   bts_rsp_if rsp_bus();

   bilinear_rgba8_texel_sampler_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   sampler_word_type pending_words[$];
   logic [31:0]   expected_colors[$];
   texel_type     texel_mirror[STORE_DEPTH];
   bit            planned_written[STORE_DEPTH];
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;
   int  send_gap;
   int  recv_gap;
   int  mismatches;
   int  quiet_cycles;
   bit  steady;

   localparam int WATCHDOG_LIMIT = 20000;

   always #10 clock = ~clock;

   function automatic int active_size(input logic [SIZE_W-1:0] r, input int maxv);
      if (r == 0) return 1;
      if (r > maxv) return maxv;
      return r;
   endfunction

   function automatic int map_axis(input logic signed [31:0] c, input int size);
      longint p;
      p = longint'(c) * size - 32768;
      if (p < 0) p = 0;
      if (p > longint'(size - 1) * 65536) p = longint'(size - 1) * 65536;
      return int'(p);
   endfunction

   // four neighbour addresses plus the two fractions
   function automatic void footprint(input logic signed [31:0] u, input logic signed [31:0] v,
                                     output int addr[4], output longint fx,
                                     output longint fy);
      int w, h, px, py, x0, y0, x1, y1;
      w = active_size(width_reg, MAX_WIDTH);
      h = active_size(height_reg, MAX_HEIGHT);
      px = map_axis(u, w);
      py = map_axis(v, h);
      x0 = px >> 16;
      y0 = py >> 16;
      fx = px & 16'hFFFF;
      fy = py & 16'hFFFF;
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
      addr[0] = y0 * w + x0;
      addr[1] = y0 * w + x1;
      addr[2] = y1 * w + x0;
      addr[3] = y1 * w + x1;
   endfunction

   function automatic logic [31:0] filter_sample(input logic signed [31:0] u,
                                                 input logic signed [31:0] v);
      int addr[4];
      longint fx, fy, top, bot, acc, val;
      logic [31:0] color;
      footprint(u, v, addr, fx, fy);
      color = '0;
      for (int ch = 0; ch < 4; ch++) begin
         top = longint'(texel_mirror[addr[0]][8*ch +: 8]) * (65536 - fx)
             + longint'(texel_mirror[addr[1]][8*ch +: 8]) * fx;
         bot = longint'(texel_mirror[addr[2]][8*ch +: 8]) * (65536 - fx)
             + longint'(texel_mirror[addr[3]][8*ch +: 8]) * fx;
         acc = top * (65536 - fy) + bot * fy + 64'h8000_0000;
         val = acc >>> 32;
         if (val > 255) val = 255;
         color[8*ch +: 8] = val[7:0];
      end
      return color;
   endfunction

   task automatic queue_write(input int idx, input texel_type value);
      sampler_word_type wd;
      wd.mode = MODE_WRITE;
      wd.texel_index = addr_type'(idx);
      wd.texel_value = value;
      wd.coord_u = $urandom;
      wd.coord_v = $urandom;
      planned_written[idx] = 1'b1;
      pending_words.insert(pending_words.size(), wd);
   endtask

   // fills any unwritten neighbour first so no unwritten entry is read
   task automatic queue_sample(input logic signed [31:0] u, input logic signed [31:0] v);
      sampler_word_type wd;
      int addr[4];
      longint fx, fy;
      footprint(u, v, addr, fx, fy);
      for (int k = 0; k < 4; k++) begin
         if (!planned_written[addr[k]]) queue_write(addr[k], $urandom);
      end
      wd.mode = MODE_SAMPLE;
      wd.texel_index = addr_type'($urandom);
      wd.texel_value = $urandom;
      wd.coord_u = u;
      wd.coord_v = v;
      pending_words.insert(pending_words.size(), wd);
   endtask

   task automatic drain_and_settle();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_bus.valid || expected_colors.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [SIZE_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      if (idx == CSR_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [31:0] random_coord();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh0001_0000 : 32'sh0;
         default: return $signed($urandom_range(0, 32'h14000)) - 32'sh2000;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (!steady && $urandom_range(0, 19) == 0) begin
            send_gap <= $urandom_range(0, 10);
            req_bus.valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            sampler_word_type wd;
            wd = pending_words.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.mode <= wd.mode;
            req_bus.texel_index <= wd.texel_index;
            req_bus.texel_value <= wd.texel_value;
            req_bus.coord_u <= wd.coord_u;
            req_bus.coord_v <= wd.coord_v;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap <= 0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 19) == 0) begin
         recv_gap <= $urandom_range(0, 10);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.mode == MODE_WRITE) texel_mirror[req_bus.texel_index] = req_bus.texel_value;
            else expected_colors.insert(expected_colors.size(),
                                        filter_sample(req_bus.coord_u, req_bus.coord_v));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_colors.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word: filtered_color %h",
                                              rsp_bus.filtered_color);
            end else begin
               logic [31:0] want;
               want = expected_colors.pop_front();
               if (rsp_bus.filtered_color !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("filtered_color mismatch: expected %h actual %h",
                              want, rsp_bus.filtered_color);
               end
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      logic signed [31:0] corners[7];
      int phase_w[10];
      int phase_h[10];
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_WRITE;
      req_bus.texel_index = '0;
      req_bus.texel_value = '0;
      req_bus.coord_u = '0;
      req_bus.coord_v = '0;
      rsp_bus.ready = 1'b0;
      mismatches = 0;
      quiet_cycles = 0;
      steady = 1'b0;
      width_reg = 10'd512;
      height_reg = 10'd512;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: 4x4 image, extreme texels and coordinates
      write_csr(CSR_IMAGE_WIDTH, 10'd4);
      write_csr(CSR_IMAGE_HEIGHT, 10'd4);
      for (int i = 0; i < 16; i++)
         queue_write(i, (i % 3 == 0) ? 32'hFFFF_FFFF : (i % 3 == 1) ? 32'h0 : 32'h00FF_7F01);
      corners = '{32'sh0, 32'sh0001_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh0000_2000, 32'sh0000_FFFF, 32'shFFFF_FFFF};
      for (int i = 0; i < 7; i++) queue_sample(corners[i], corners[6 - i]);
      queue_write(STORE_DEPTH - 1, 32'hFFFF_FFFF);
      drain_and_settle();

      phase_w = '{1, 0, 512, 1023, 3, 512, 1, 16, 700, 7};
      phase_h = '{1, 0, 512, 600, 7, 1, 512, 9, 2, 5};
      for (int p = 0; p < 10; p++) begin
         write_csr(CSR_IMAGE_WIDTH, SIZE_W'(phase_w[p]));
         write_csr(CSR_IMAGE_HEIGHT, SIZE_W'(phase_h[p]));
         if (p == 9) steady = 1'b1;
         for (int n = 0; n < 75; n++) begin
            if ($urandom_range(0, 4) == 0)
               queue_write($urandom_range(0, STORE_DEPTH - 1), $urandom);
            queue_sample(random_coord(), random_coord());
         end
         drain_and_settle();
      end

      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- bilinear_rgba8_texel_sampler_unit.f -----
rtl/bts_pkg.sv
rtl/bts_req_if.sv
rtl/bts_filter.sv
rtl/bilinear_rgba8_texel_sampler_unit.sv
tb/tb.sv
